@@ sv/best_fit_host_allocator_top_assert.svh @@
// Assertion macros used by the checker file of the allocator.
`ifndef BEST_FIT_HOST_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_HOST_ALLOCATOR_TOP_ASSERT_SVH

// Clocked assertion with reset masking.
`define BFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form: the consequent must hold in the next cycle.
`define BFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bfha_pkg.sv @@
// Shared types and constants of the best-fit host allocator.
package bfha_pkg;

  localparam int unsigned HOSTS_DEF  = 16;
  localparam int unsigned QUEUES_DEF = 8;
  localparam int unsigned MAX_GRANT  = 16;

  localparam logic [2:0] REASON_NONE  = 3'd0;
  localparam logic [2:0] REASON_EXCL  = 3'd1;
  localparam logic [2:0] REASON_TYPE  = 3'd2;
  localparam logic [2:0] REASON_GPUS  = 3'd3;
  localparam logic [2:0] REASON_MEM   = 3'd4;
  localparam logic [2:0] REASON_STOR  = 3'd5;
  localparam logic [2:0] REASON_CPUS  = 3'd6;
  localparam logic [2:0] REASON_NOHST = 3'd7;

  localparam logic KIND_HOST_WR = 1'b0;
  localparam logic KIND_JOB     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  host_index;
    logic        host_ok;
    logic [9:0]  cpus;
    logic [23:0] mem_mb;
    logic [31:0] disk_mb;
    logic [3:0]  gpus;
    logic [3:0]  accel_type;
    logic [7:0]  job_count;
    logic [7:0]  count_limit;
    logic [7:0]  queue_sel;
    logic        exclusive;
  } bfha_in_t;

  typedef struct packed {
    logic       granted;
    logic [3:0] host_index_res;
    logic [2:0] hold_cause;
    logic       last;
  } bfha_out_t;

  // One host table entry; the health mark is kept in flip-flops apart.
  typedef struct packed {
    logic [9:0]  cpus;
    logic [23:0] mem_mb;
    logic [31:0] disk_mb;
    logic [3:0]  gpus;
    logic [3:0]  accel_type;
    logic [7:0]  qmask;
    logic [7:0]  running;
    logic [7:0]  limit;
    logic        excl;
  } host_entry_t;

  typedef struct packed {
    logic load_job;
    logic host_wr;
    logic cnt_clr;
    logic scan_rd;
    logic sel_start;
    logic sel_rd;
    logic emit_pend;
    logic emit_grant;
    logic dbt_rd;
    logic dbt_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic pend;
    logic grant_last;
    logic out_busy;
  } dp_sts_t;

endpackage

@@ sv/bfha_dp.sv @@
// Datapath: host table memory, scan filter, best-fit search, debit and result register.
module bfha_dp #(
  parameter int unsigned HOSTS  = bfha_pkg::HOSTS_DEF,
  parameter int unsigned QUEUES = bfha_pkg::QUEUES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfha_pkg::bfha_in_t  in_data_i,
  input  bfha_pkg::dp_cmd_t   cmd_i,
  output bfha_pkg::dp_sts_t   sts_o,
  output bfha_pkg::bfha_out_t out_data_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import bfha_pkg::*;

  localparam int unsigned HW = $clog2(HOSTS);
  localparam int unsigned FW = $clog2(HOSTS + 1);

  host_entry_t       mem_q [HOSTS];
  host_entry_t       rd_q;
  host_entry_t       mem_wd;
  logic [HW-1:0]     mem_wa;
  logic              mem_we;
  logic [HW-1:0]     rd_addr;

  logic [HOSTS-1:0]  healthy_q;
  logic [HOSTS-1:0]  ok_q;
  logic [HW-1:0]     cnt_q;
  logic [HW-1:0]     rd_idx_q;
  logic              rd_scan_q;
  logic              rd_sel_q;
  bfha_in_t          job_q;
  logic [7:0]        need_q;
  logic [FW-1:0]     found_q;
  logic              seen_excl_q, seen_type_q, seen_gpus_q;
  logic              seen_mem_q, seen_stor_q, seen_cpus_q;
  logic [HW-1:0]     best_q;
  logic [9:0]        best_cpu_q;
  logic              best_vld_q;
  logic [4:0]        k_q;
  bfha_out_t         out_q;
  logic              out_valid_q;

  logic [2:0]        qid;
  logic              member, cand, hit;
  logic              f_excl, f_cpu, f_mem, f_stor, f_gpu, f_type, fit;
  logic              wr_in_range;
  logic              pend;
  logic [2:0]        reason;

  assign wr_in_range = 32'(in_data_i.host_index) < 32'(HOSTS);

  // Filter of the entry read in the previous cycle against the job.
  always_comb begin
    qid    = job_q.queue_sel[2:0];
    member = (32'(qid) < 32'(QUEUES)) && rd_q.qmask[qid];
    cand   = healthy_q[rd_idx_q] && (rd_q.running < rd_q.limit);
    hit    = rd_scan_q && member && cand;
    f_excl = rd_q.excl || (job_q.exclusive && (rd_q.running != 8'd0));
    f_cpu  = rd_q.cpus < job_q.cpus;
    f_mem  = rd_q.mem_mb < job_q.mem_mb;
    f_stor = rd_q.disk_mb < job_q.disk_mb;
    f_gpu  = (job_q.gpus != 4'd0) && (rd_q.gpus < job_q.gpus);
    f_type = (job_q.accel_type != 4'd0) && (rd_q.accel_type != job_q.accel_type);
    fit    = !f_excl && !f_cpu && !f_mem && !f_stor && !f_gpu && !f_type;
  end

  always_comb begin
    if (seen_excl_q) begin
      reason = REASON_EXCL;
    end else if (seen_type_q) begin
      reason = REASON_TYPE;
    end else if (seen_gpus_q) begin
      reason = REASON_GPUS;
    end else if (seen_mem_q) begin
      reason = REASON_MEM;
    end else if (seen_stor_q) begin
      reason = REASON_STOR;
    end else if (seen_cpus_q) begin
      reason = REASON_CPUS;
    end else begin
      reason = REASON_NOHST;
    end
  end

  assign pend = (32'(found_q) < 32'(need_q)) || (32'(need_q) > MAX_GRANT);

  assign sts_o.cnt_last   = cnt_q == HW'(HOSTS - 1);
  assign sts_o.pend       = pend;
  assign sts_o.grant_last = (8'(k_q) + 8'd1) == need_q;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  // Memory ports: host writes from the input, debits of the selected host.
  always_comb begin
    rd_addr = cmd_i.dbt_rd ? best_q : cnt_q;
    mem_we  = (cmd_i.host_wr && wr_in_range) || cmd_i.dbt_wr;
    if (cmd_i.host_wr) begin
      mem_wa            = HW'(in_data_i.host_index);
      mem_wd.cpus       = in_data_i.cpus;
      mem_wd.mem_mb     = in_data_i.mem_mb;
      mem_wd.disk_mb    = in_data_i.disk_mb;
      mem_wd.gpus       = in_data_i.gpus;
      mem_wd.accel_type = in_data_i.accel_type;
      mem_wd.qmask      = in_data_i.queue_sel;
      mem_wd.running    = in_data_i.job_count;
      mem_wd.limit      = in_data_i.count_limit;
      mem_wd.excl       = in_data_i.exclusive;
    end else begin
      mem_wa            = best_q;
      mem_wd            = rd_q;
      mem_wd.cpus       = (rd_q.cpus >= job_q.cpus) ? rd_q.cpus - job_q.cpus : 10'd0;
      mem_wd.mem_mb     = (rd_q.mem_mb >= job_q.mem_mb) ? rd_q.mem_mb - job_q.mem_mb : 24'd0;
      mem_wd.disk_mb    = (rd_q.disk_mb >= job_q.disk_mb) ?
                          rd_q.disk_mb - job_q.disk_mb : 32'd0;
      mem_wd.gpus       = (rd_q.gpus >= job_q.gpus) ? rd_q.gpus - job_q.gpus : 4'd0;
      mem_wd.running    = (rd_q.running != 8'hFF) ? rd_q.running + 8'd1 : rd_q.running;
      mem_wd.excl       = rd_q.excl || job_q.exclusive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_job) begin
      job_q  <= in_data_i;
      need_q <= (in_data_i.count_limit == 8'd0) ? 8'd1 : in_data_i.count_limit;
    end
    rd_idx_q <= rd_addr;
    if (rd_sel_q && ok_q[rd_idx_q] && (!best_vld_q || rd_q.cpus < best_cpu_q)) begin
      best_q     <= rd_idx_q;
      best_cpu_q <= rd_q.cpus;
    end
    if (cmd_i.emit_pend) begin
      out_q.granted        <= 1'b0;
      out_q.host_index_res <= 4'd0;
      out_q.hold_cause     <= reason;
      out_q.last           <= 1'b1;
    end else if (cmd_i.emit_grant) begin
      out_q.granted        <= 1'b1;
      out_q.host_index_res <= 4'(best_q);
      out_q.hold_cause     <= REASON_NONE;
      out_q.last           <= sts_o.grant_last;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      healthy_q   <= '0;
      ok_q        <= '0;
      cnt_q       <= '0;
      rd_scan_q   <= 1'b0;
      rd_sel_q    <= 1'b0;
      found_q     <= '0;
      seen_excl_q <= 1'b0;
      seen_type_q <= 1'b0;
      seen_gpus_q <= 1'b0;
      seen_mem_q  <= 1'b0;
      seen_stor_q <= 1'b0;
      seen_cpus_q <= 1'b0;
      best_vld_q  <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_scan_q <= cmd_i.scan_rd;
      rd_sel_q  <= cmd_i.sel_rd;
      if (cmd_i.host_wr && wr_in_range) begin
        healthy_q[HW'(in_data_i.host_index)] <= in_data_i.host_ok;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd || cmd_i.sel_rd) begin
        cnt_q <= cnt_q + HW'(1);
      end
      if (cmd_i.load_job) begin
        ok_q        <= '0;
        found_q     <= '0;
        seen_excl_q <= 1'b0;
        seen_type_q <= 1'b0;
        seen_gpus_q <= 1'b0;
        seen_mem_q  <= 1'b0;
        seen_stor_q <= 1'b0;
        seen_cpus_q <= 1'b0;
        k_q         <= '0;
      end else if (rd_scan_q) begin
        ok_q[rd_idx_q] <= hit && fit;
        if (hit && fit) begin
          found_q <= found_q + FW'(1);
        end
        // Only the first failing check of a host counts.
        if (hit) begin
          if (f_excl) begin
            seen_excl_q <= 1'b1;
          end else if (f_cpu) begin
            seen_cpus_q <= 1'b1;
          end else if (f_mem) begin
            seen_mem_q <= 1'b1;
          end else if (f_stor) begin
            seen_stor_q <= 1'b1;
          end else if (f_gpu) begin
            seen_gpus_q <= 1'b1;
          end else if (f_type) begin
            seen_type_q <= 1'b1;
          end
        end
      end else if (cmd_i.emit_grant) begin
        ok_q[best_q] <= 1'b0;
      end
      if (cmd_i.sel_start) begin
        best_vld_q <= 1'b0;
      end else if (rd_sel_q && ok_q[rd_idx_q]) begin
        best_vld_q <= 1'b1;
      end
      if (cmd_i.dbt_wr) begin
        k_q <= k_q + 5'd1;
      end
      if (cmd_i.emit_pend || cmd_i.emit_grant) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/bfha_ctrl.sv @@
// Controller state machine sequencing scan, selection passes, debits and results.
module bfha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_stall_o,
  input  bfha_pkg::dp_sts_t sts_i,
  output bfha_pkg::dp_cmd_t cmd_o
);
  import bfha_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_END, ST_DECIDE, ST_SEL, ST_SEL_END,
    ST_GRANT, ST_DBT_RD, ST_DBT_WR, ST_PEND
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = state_q != ST_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_JOB) begin
            cmd_o.load_job = 1'b1;
            cmd_o.cnt_clr  = 1'b1;
            state_d        = ST_SCAN;
          end else begin
            cmd_o.host_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (sts_i.pend) begin
          state_d = ST_PEND;
        end else begin
          cmd_o.sel_start = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd_o.sel_rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_SEL_END;
        end
      end
      ST_SEL_END: state_d = ST_GRANT;
      ST_GRANT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_grant = 1'b1;
          state_d          = ST_DBT_RD;
        end
      end
      ST_DBT_RD: begin
        cmd_o.dbt_rd = 1'b1;
        state_d      = ST_DBT_WR;
      end
      ST_DBT_WR: begin
        cmd_o.dbt_wr = 1'b1;
        if (sts_i.grant_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.sel_start = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = ST_SEL;
        end
      end
      ST_PEND: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_pend = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/best_fit_host_allocator_top.sv @@
// Top level of the best-fit host allocator.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i/in_stall_o  | bfha_in_t  (host write or job)
//   out     | output    | out_valid_o/out_stall_i | bfha_out_t (grant or pend)
//
// A job first scans the table through its single read port, then runs, for each
// granted host, a full selection pass plus a read-modify-write debit, or else pends.
// Reset clears the health marks, so no host is usable until it is written.
// A stalled output holds its word; the job waits in place until it frees.
module best_fit_host_allocator_top #(
  parameter int unsigned HOSTS  = bfha_pkg::HOSTS_DEF,
  parameter int unsigned QUEUES = bfha_pkg::QUEUES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bfha_pkg::bfha_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bfha_pkg::bfha_out_t out_data_o
);
  import bfha_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfha_dp #(
    .HOSTS  (HOSTS),
    .QUEUES (QUEUES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

@@ sv/bfha_checker.sv @@
// Port-level checker for the allocator and its bind to the top level.
`include "best_fit_host_allocator_top_assert.svh"

module bfha_port_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input bfha_pkg::bfha_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bfha_pkg::bfha_out_t out_data_o
);
  import bfha_pkg::*;

  logic pend_form_ok;

  assign pend_form_ok = out_data_o.last && (out_data_o.host_index_res == 4'd0);

  `BFHA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "out word dropped")
  `BFHA_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o), "out word changed")
  `BFHA_ASSERT(a_pend_form, out_valid_o && !out_data_o.granted |-> pend_form_ok, "bad pend word")
  `BFHA_ASSERT_NEXT(a_job_busy, in_valid_i && !in_stall_o && in_data_i.kind == KIND_JOB, in_stall_o, "job not held")
  `BFHA_ASSERT_NEXT(a_wr_free, in_valid_i && !in_stall_o && in_data_i.kind == KIND_HOST_WR, !in_stall_o, "host write stalled")

endmodule

bind best_fit_host_allocator_top bfha_port_props u_bfha_port_props (.*);
